/* design/sle_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the list engine.
`default_nettype none

package sle_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 7;
    localparam int CAP_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic accept;
        logic start_move;
        logic move;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_move;
        logic move_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/sle_if.sv */
// Request and response channel interfaces of the list engine.
`default_nettype none

interface sle_req_if import sle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;

    modport source (output valid, output operation, output position, output value_in,
                    input ready);
    modport sink (input valid, input operation, input position, input value_in,
                  output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value_out;
    logic [LEN_W-1:0] length;

    modport source (output valid, output status, output value_out, output length,
                    input ready);
    modport sink (input valid, input status, input value_out, input length,
                  output ready);
endinterface

`default_nettype wire

/* design/sle_ctrl.sv */
// Controller state machine that sequences each list transaction.
`default_nettype none

module sle_ctrl import sle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_MOVE   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.need_move) begin
                    o_cmd.start_move = 1'b1;
                    n_state          = S_MOVE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                if (i_sts.move_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/sle_dp.sv */
// Datapath with element memory, count, capacity register and response register.
`default_nettype none

module sle_dp import sle_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value_in,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_rsp_ready,
    output logic             o_rsp_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_value_out,
    output logic [LEN_W-1:0] o_length
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [ELEM_WIDTH-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]       r_op;
    logic [POS_W-1:0]      r_pos;
    logic [ELEM_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CAP_W-1:0]      r_cap;
    logic [AW-1:0]         r_ptr;
    logic [CW-1:0]         r_left;
    logic                  r_pend;
    logic [AW-1:0]         r_pend_addr;
    logic                  r_first;
    logic                  r_wb;
    logic                  r_up;
    logic [ELEM_WIDTH-1:0] r_rdata;
    logic [ELEM_WIDTH-1:0] r_vcap;
    logic                  r_out_valid;
    logic [ST_W-1:0]       r_status;
    logic [VAL_W-1:0]      r_vout;
    logic [LEN_W-1:0]      r_length;

    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       cap_ext;
    logic [CMPW-1:0]       limit;
    logic [AW-1:0]         pos_addr;
    logic [CW-1:0]         tail;
    logic                  is_get;
    logic                  is_set;
    logic                  is_ins;
    logic                  is_del;
    logic                  is_clr;
    logic                  in_range;
    logic                  ins_range;
    logic                  full;
    logic                  get_ok;
    logic                  set_ok;
    logic                  ins_ok;
    logic                  del_ok;
    logic                  rd_en;
    logic                  mv_we;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic [ST_W-1:0]       n_status;
    logic [ELEM_WIDTH-1:0] n_vout;

    assign pos_ext   = CMPW'(r_pos);
    assign cnt_ext   = CMPW'(r_count);
    assign cap_ext   = CMPW'(r_cap);
    assign limit     = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
    assign pos_addr  = AW'(pos_ext - CMPW'(1));
    assign tail      = CW'(cnt_ext - pos_ext + CMPW'(1));

    assign is_get    = (r_op == OP_GET);
    assign is_set    = (r_op == OP_SET);
    assign is_ins    = (r_op == OP_INSERT);
    assign is_del    = (r_op == OP_DELETE);
    assign is_clr    = (r_op == OP_CLEAR);

    assign in_range  = (r_pos != '0) && (pos_ext <= cnt_ext);
    assign ins_range = (r_pos != '0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign full      = (cnt_ext >= limit);
    assign get_ok    = is_get && in_range;
    assign set_ok    = is_set && in_range;
    assign del_ok    = is_del && in_range;
    assign ins_ok    = is_ins && !full && ins_range;

    assign rd_en     = i_cmd.move && (r_left != '0);
    assign mv_we     = i_cmd.move && r_pend && !r_first && r_wb;
    assign mem_we    = mv_we || (i_cmd.finish && (ins_ok || set_ok));
    assign mem_waddr = mv_we ? (r_up ? r_pend_addr - AW'(1) : r_pend_addr + AW'(1)) : pos_addr;
    assign mem_wdata = mv_we ? r_rdata : r_val;

    assign o_sts.need_move = get_ok || del_ok || ins_ok;
    assign o_sts.move_done = (r_left == '0) && !r_pend;
    assign o_sts.out_free  = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_vout   = '0;
        if (is_ins) begin
            if (full) begin
                n_status = ST_FULL;
            end else if (!ins_range) begin
                n_status = ST_BADPOS;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (is_get || is_set || is_del) begin
            if (!in_range) begin
                n_status = ST_BADPOS;
            end else if (is_get) begin
                n_vout = r_vcap;
            end else if (is_del) begin
                n_vout  = r_vcap;
                n_count = r_count - CW'(1);
            end
        end else if (is_clr) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.start_move) begin
                r_left <= is_get ? CW'(1) : tail;
                r_pend <= 1'b0;
            end else if (i_cmd.move) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_left <= r_left - CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= ELEM_WIDTH'(i_value_in);
        end
        if (i_cmd.start_move) begin
            r_ptr   <= is_ins ? AW'(cnt_ext - CMPW'(1)) : pos_addr;
            r_up    <= !is_ins;
            r_first <= !is_ins;
            r_wb    <= !is_get;
        end else if (i_cmd.move) begin
            if (rd_en) begin
                r_ptr       <= r_up ? r_ptr + AW'(1) : r_ptr - AW'(1);
                r_pend_addr <= r_ptr;
            end
            if (r_pend && r_first) begin
                r_vcap  <= r_rdata;
                r_first <= 1'b0;
            end
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_vout   <= VAL_W'(n_vout);
            r_length <= LEN_W'(n_count);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_length    = r_length;

`ifndef NO_ASSERTIONS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && rd_en) |-> (mem_waddr != r_ptr))
        else $error("memory write and read hit the same entry");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_pend && (r_left == '0)))
        else $error("response issued before the element move drained");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= CMPW'(DEPTH))
        else $error("element count exceeds store depth");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && ins_ok) |=> (CMPW'(r_count) <= limit))
        else $error("insert grew the list past its limit");
`endif

endmodule

`default_nettype wire

/* design/sequential_list_engine.sv */
// Sequential list engine top level: ordered list with get, set, insert, delete and clear.
// Get reads one element from memory; delete and insert below the end of the list shift
// count-pos+1 elements through it (at most 64); insert at the end, set, clear and
// rejected requests move no elements.
// Throughput: one transaction at a time, next request taken in the cycle after the result
// registers, which waits until the last response is taken; shifts move one element per cycle.
// Reset: synchronous active low; empties the list and restores capacity to 64.
`default_nettype none

module sequential_list_engine import sle_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sle_req_if.sink          i_req,
    sle_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    assign i_req.ready = req_ready;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sle_dp #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_req.operation),
        .i_position  (i_req.position),
        .i_value_in  (i_req.value_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_value_out (o_rsp.value_out),
        .o_length    (o_rsp.length)
    );

endmodule

`default_nettype wire

/* test/sle_list_checker.sv */
// Checker for the list engine: tracks the list, predicts every result and compares responses.
`timescale 1ns / 100ps

module sle_list_checker import sle_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sle_req_if               i_req,
    sle_rsp_if               i_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output logic [LEN_W-1:0] o_list_len
);

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value_out;
        logic [LEN_W-1:0] length;
    } t_list_result;

    logic [VAL_W-1:0] elements [DEPTH];
    int               elem_count;
    logic [CAP_W-1:0] capacity_reg;
    t_list_result     expected_results [$];
    int               mismatches;
    int               results_seen;

    initial begin
        elem_count   = 0;
        capacity_reg = CAP_RESET;
        mismatches   = 0;
        results_seen = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_list_len   = '0;
    end

    function automatic t_list_result next_list_result(input logic [OP_W-1:0]  op,
                                                      input logic [POS_W-1:0] pos_bits,
                                                      input logic [VAL_W-1:0] value);
        t_list_result res;
        int           pos;
        int           lim;
        pos = pos_bits;
        lim = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        res.status    = ST_OK;
        res.value_out = '0;
        case (op)
            OP_GET: begin
                if (pos < 1 || pos > elem_count) res.status = ST_BADPOS;
                else res.value_out = elements[pos-1];
            end
            OP_SET: begin
                if (pos < 1 || pos > elem_count) res.status = ST_BADPOS;
                else elements[pos-1] = value;
            end
            OP_INSERT: begin
                if (elem_count >= lim) begin
                    res.status = ST_FULL;
                end else if (pos < 1 || pos > elem_count + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = elem_count; i >= pos; i--) elements[i] = elements[i-1];
                    elements[pos-1] = value;
                    elem_count++;
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > elem_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.value_out = elements[pos-1];
                    for (int i = pos; i < elem_count; i++) elements[i-1] = elements[i];
                    elem_count--;
                end
            end
            OP_CLEAR: begin
                elem_count = 0;
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(elem_count);
        return res;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
                     $time, results_seen, field, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            elem_count   = 0;
            capacity_reg = CAP_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) capacity_reg = i_cfg_wdata;
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h",
                             $time, i_rsp.status, i_rsp.value_out, i_rsp.length);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("status", 32'(want.status), 32'(i_rsp.status));
                    report_field("value_out", want.value_out, i_rsp.value_out);
                    report_field("length", 32'(want.length), 32'(i_rsp.length));
                    results_seen++;
                end
            end
            if (i_req.valid && i_req.ready)
                expected_results.push_back(next_list_result(i_req.operation, i_req.position,
                                                            i_req.value_in));
        end
        o_pending    <= expected_results.size();
        o_list_len   <= LEN_W'(elem_count);
        o_fail_count <= mismatches;
        o_checked    <= results_seen;
    end

endmodule

/* test/sequential_list_engine_tb.sv */
// Testbench top for the list engine: clock, reset, request and capacity stimulus, verdict.
`timescale 1ns / 100ps

module sequential_list_engine_tb;
    import sle_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int POS_MAX     = (1 << POS_W) - 1;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    sle_req_if req_ch ();
    sle_rsp_if rsp_ch ();

    int               fail_count;
    int               pending;
    int               checked;
    logic [LEN_W-1:0] list_len_hint;

    bit calm;
    int sent_count;
    int cap_writes;
    int idle_cycles;

    sequential_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .ELEM_WIDTH (VAL_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    sle_list_checker #(
        .DEPTH (LIST_DEPTH)
    ) list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_list_len   (list_len_hint)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input int n, input bit for_insert);
        int top_pos;
        int r;
        top_pos = for_insert ? n + 1 : n;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return POS_W'($urandom_range(0, POS_MAX));
        if (r < 18) return POS_W'(top_pos + 1);
        if (top_pos == 0) return POS_W'($urandom_range(0, 3));
        if (r < 30) return 1;
        if (r < 42) return POS_W'(top_pos);
        return POS_W'($urandom_range(1, top_pos));
    endfunction

    task automatic send_req(input logic [OP_W-1:0]  op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] value);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.position  <= pos;
        req_ch.value_in  <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    task automatic fill_to(input int n);
        while (list_len_hint < n)
            send_req(OP_INSERT, POS_W'($urandom_range(1, list_len_hint + 1)), pick_value());
    endtask

    task automatic send_random(input int clear_w);
        int              r;
        int              n;
        logic [OP_W-1:0] op;
        n = list_len_hint;
        r = $urandom_range(0, 99);
        if (r < clear_w) op = OP_CLEAR;
        else if (r < clear_w + 4) op = OP_W'(OP_CLEAR + $urandom_range(1, 3));
        else if (r < 38) op = OP_INSERT;
        else if (r < 58) op = OP_DELETE;
        else if (r < 78) op = OP_GET;
        else op = OP_SET;
        send_req(op, pick_position(n, op == OP_INSERT), pick_value());
    endtask

    task automatic run_random(input int count, input int clear_w);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (k == count / 2) drain();
            send_random(clear_w);
        end
        calm = 1'b0;
    endtask

    // hold response ready low for random stretches
    initial begin
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        calm       = 1'b0;
        sent_count = 0;
        cap_writes = 0;
        idle_cycles = 0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_GET;
        req_ch.position  <= '0;
        req_ch.value_in  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(OP_GET, 1, '0);
        send_req(OP_DELETE, 1, '0);
        send_req(OP_SET, 1, 32'h1111_1111);
        send_req(OP_INSERT, 0, 32'h2222_2222);
        send_req(OP_INSERT, 2, 32'h3333_3333);
        send_req(OP_INSERT, 1, 32'hFFFF_FFFF);
        send_req(OP_INSERT, 1, 32'h0000_0000);
        send_req(OP_INSERT, 3, 32'hA5A5_A5A5);
        send_req(OP_INSERT, 2, 32'h5A5A_5A5A);
        send_req(OP_GET, 4, '0);
        send_req(OP_GET, 1, '0);
        send_req(OP_GET, 0, '0);
        send_req(OP_GET, 5, '0);
        send_req(OP_GET, POS_W'(POS_MAX), '1);
        send_req(OP_SET, 3, 32'h1234_5678);
        send_req(OP_SET, 5, 32'h8765_4321);
        send_req(OP_DELETE, 4, '0);
        send_req(OP_DELETE, 1, '0);
        send_req(OP_DELETE, 0, '0);
        send_req(OP_W'(OP_CLEAR + 1), 1, '1);
        send_req(OP_W'(OP_CLEAR + 2), 2, '1);
        send_req(OP_W'(OP_CLEAR + 3), POS_W'(POS_MAX), '1);
        send_req(OP_CLEAR, POS_W'(POS_MAX), '1);
        send_req(OP_INSERT, 1, 32'h0F0F_0F0F);
        send_req(OP_GET, 1, '0);

        // capacity above the store size saturates; fill and push past full
        write_capacity(7'd127);
        fill_to(LIST_DEPTH);
        send_req(OP_INSERT, 70, pick_value());
        send_req(OP_INSERT, 1, pick_value());
        run_random(120, 2);

        write_capacity(7'd0);
        run_random(60, 0);

        write_capacity(7'd1);
        run_random(60, 5);

        // lower capacity below the current count
        write_capacity(CAP_RESET);
        fill_to(30);
        write_capacity(7'd5);
        run_random(80, 0);

        for (int k = 0; k < 3; k++) begin
            write_capacity(CAP_W'($urandom_range(1, 127)));
            run_random(100, 4);
        end

        write_capacity(CAP_RESET);
        run_random(80, 3);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests over %0d capacity settings, %0d results compared;",
                 sent_count, cap_writes, checked);
        $display("covered all operation codes, full and bad-position cases, capacities 0..127.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
